### hw/rtl/assert_macros.svh
// Assertion helpers, included by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition on the next edge.
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error(msg);

`endif

### hw/rtl/rotenc_pkg.sv
package rotenc_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned MsCfgWidth = 16;
   localparam int unsigned StepWidth  = 7;
   localparam int unsigned DeltaWidth = 8;
   localparam int unsigned CsrIdxWidth  = 8;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned RspDataWidth = 24;

   localparam logic [MsCfgWidth-1:0] DebounceReset  = 16'd50;
   localparam logic [MsCfgWidth-1:0] LongPressReset = 16'd1000;
   localparam logic [StepWidth-1:0]  FineReset      = 7'd1;
   localparam logic [StepWidth-1:0]  CoarseReset    = 7'd10;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEBOUNCE   = 8'd0,
      CSR_LONG_PRESS = 8'd1,
      CSR_FINE_STEP  = 8'd2,
      CSR_COARSE_STEP = 8'd3
   } csr_idx_type;

   typedef struct packed {
      logic [MsCfgWidth-1:0] debounce_ms;
      logic [MsCfgWidth-1:0] long_press_ms;
      logic [StepWidth-1:0]  fine_step;
      logic [StepWidth-1:0]  coarse_step;
   } cfg_type;

   typedef struct packed {
      logic long_press;
      logic short_press;
      logic coarse_mode;
   } btn_evt_type;

   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic                 button_level;
      logic                 dt_level;
      logic                 clk_level;
   } sample_type;

   typedef struct packed {
      logic [StepWidth-1:0]        step_now;
      logic                        short_press;
      logic                        long_press;
      logic signed [DeltaWidth-1:0] delta;
   } result_type;

endpackage

### hw/rtl/rotenc_csr.sv
module rotenc_csr
   import rotenc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [CsrIdxWidth-1:0]  wr_index,
   input  logic [CsrDataWidth-1:0] wr_data,
   output cfg_type                 cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_DEBOUNCE:    cfg_in.debounce_ms   = wr_data;
            CSR_LONG_PRESS:  cfg_in.long_press_ms = wr_data;
            CSR_FINE_STEP:   cfg_in.fine_step     = wr_data[StepWidth-1:0];
            CSR_COARSE_STEP: cfg_in.coarse_step   = wr_data[StepWidth-1:0];
            default:         cfg_in = cfg_ff; // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DebounceReset;
         cfg_ff.long_press_ms <= LongPressReset;
         cfg_ff.fine_step     <= FineReset;
         cfg_ff.coarse_step   <= CoarseReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/rotenc_button.sv
module rotenc_button
   import rotenc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 button_level,
   input  logic [TimeWidth-1:0] now_ms,
   input  cfg_type              cfg,
   output btn_evt_type          evt
);

   logic                 pressed_ff, pressed_in;
   logic                 action_done_ff, action_done_in;
   logic                 coarse_ff, coarse_in;
   logic [TimeWidth-1:0] press_start_ff, press_start_in;
   logic [TimeWidth-1:0] last_release_ff, last_release_in;
   logic [TimeWidth-1:0] since_release, since_press;
   logic [TimeWidth-1:0] debounce_ext, long_ext;
   logic                 btn_down;

   assign btn_down      = ~button_level;
   assign since_release = now_ms - last_release_ff;
   assign since_press   = now_ms - press_start_ff;
   assign debounce_ext  = {{(TimeWidth-MsCfgWidth){1'b0}}, cfg.debounce_ms};
   assign long_ext      = {{(TimeWidth-MsCfgWidth){1'b0}}, cfg.long_press_ms};

   always_comb begin
      pressed_in      = pressed_ff;
      action_done_in  = action_done_ff;
      coarse_in       = coarse_ff;
      press_start_in  = press_start_ff;
      last_release_in = last_release_ff;
      evt.long_press  = 1'b0;
      evt.short_press = 1'b0;
      priority if (btn_down && !pressed_ff) begin
         if (since_release > debounce_ext) begin
            pressed_in     = 1'b1;
            press_start_in = now_ms;
            action_done_in = 1'b0;
         end
      end else if (btn_down && pressed_ff) begin
         if (!action_done_ff && (since_press > long_ext)) begin
            action_done_in = 1'b1;
            evt.long_press = 1'b1;
         end
      end else if (!btn_down && pressed_ff) begin
         pressed_in      = 1'b0;
         last_release_in = now_ms;
         if (!action_done_ff && (since_press > debounce_ext)) begin
            evt.short_press = 1'b1;
            coarse_in       = ~coarse_ff;
         end
         action_done_in = 1'b0;
      end else begin
         pressed_in = pressed_ff; // released and idle: hold
      end
      evt.coarse_mode = coarse_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff      <= 1'b0;
         action_done_ff  <= 1'b0;
         coarse_ff       <= 1'b1;
         press_start_ff  <= '0;
         last_release_ff <= '0;
      end else if (advance) begin
         pressed_ff      <= pressed_in;
         action_done_ff  <= action_done_in;
         coarse_ff       <= coarse_in;
         press_start_ff  <= press_start_in;
         last_release_ff <= last_release_in;
      end
   end

endmodule

### hw/rtl/rotenc_quad.sv
module rotenc_quad
   import rotenc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        clk_level,
   input  logic                        dt_level,
   input  logic                        coarse_mode,
   input  cfg_type                     cfg,
   output logic [StepWidth-1:0]        step_now,
   output logic signed [DeltaWidth-1:0] delta
);

   logic                  prev_clk_ff;
   logic [DeltaWidth-1:0] step_ext;

   assign step_now = coarse_mode ? cfg.coarse_step : cfg.fine_step;
   assign step_ext = {1'b0, step_now};

   // falling CLK edge is a detent; DT sets the direction
   always_comb begin
      if (prev_clk_ff && !clk_level) begin
         delta = (dt_level != clk_level) ? signed'(step_ext) : signed'(-step_ext);
      end else begin
         delta = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_clk_ff <= 1'b1;
      end else if (advance) begin
         prev_clk_ff <= clk_level;
      end
   end

endmodule

### hw/rtl/rotary_encoder_with_button_top.sv
// Channel  Dir  Beat contents
// req      in   one poll sample: encoder levels, button level, ms timestamp
// rsp      out  one result per sample: detent delta, press pulses, step
// csr      in   register write: index and data, always ready
//
// A sample is taken into the input register, then processed combinationally
// through the button and encoder logic into the result register; one sample
// per cycle is sustained while rsp is not stalled.
// Synchronous active-high reset presets state; press timing starts from zero.
// A stall on rsp holds the result register; an empty input register still
// takes one more beat, then req_tready drops until the result is taken.
`include "assert_macros.svh"

module rotary_encoder_with_button_top
   import rotenc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [0] clk_level, [1] dt_level, [2] button_level, [34:3] now_ms, rest zero
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [7:0] delta, [8] long_press, [9] short_press, [16:10] step_now, rest zero
   output logic [RspDataWidth-1:0] rsp_tdata,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrDataWidth-1:0] csr_data
);

   localparam int unsigned SampleWidth = $bits(sample_type);
   localparam int unsigned ResultWidth = $bits(result_type);

   cfg_type     cfg;
   btn_evt_type evt;
   sample_type  in_data_ff;
   result_type  rsp_data_ff, rsp_data_in;
   logic        in_valid_ff, rsp_valid_ff;
   logic        advance;

   // Move the held sample on once the result register is free or draining.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   rotenc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   rotenc_button u_button (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .button_level (in_data_ff.button_level),
      .now_ms       (in_data_ff.now_ms),
      .cfg          (cfg),
      .evt          (evt)
   );

   // Encoder stage uses the step after this sample's button handling.
   rotenc_quad u_quad (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .clk_level   (in_data_ff.clk_level),
      .dt_level    (in_data_ff.dt_level),
      .coarse_mode (evt.coarse_mode),
      .cfg         (cfg),
      .step_now    (rsp_data_in.step_now),
      .delta       (rsp_data_in.delta)
   );

   assign rsp_data_in.long_press  = evt.long_press;
   assign rsp_data_in.short_press = evt.short_press;

   // Control: input and result valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata[SampleWidth-1:0];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-ResultWidth){1'b0}}, rsp_data_ff};

   `ASSERT_ALWAYS(a_press_exclusive, clock, reset,
      !(rsp_valid_ff && rsp_data_ff.long_press && rsp_data_ff.short_press),
      "long and short press reported on the same beat")
   `ASSERT_NEXT(a_advance_fills, clock, reset, advance, rsp_valid_ff,
      "processed sample did not reach the result register")
   `ASSERT_NEXT(a_short_toggles, clock, reset, advance && evt.short_press,
      u_button.coarse_ff != $past(u_button.coarse_ff),
      "short press did not toggle the step mode")
   `ASSERT_ALWAYS(a_empty_ready, clock, reset, in_valid_ff || req_tready,
      "empty input register refused a beat")

endmodule
